// ===== rtl/core/ddg_pkg.sv =====
`default_nettype none

package ddg_pkg;

    // Graph size: resources are nodes 0..COUNT-1, processes COUNT..2*COUNT-1.
    localparam int COUNT  = 8;
    localparam int NODES  = 2 * COUNT;
    localparam int NODE_W = $clog2(NODES);
    localparam int CNT_W  = $clog2(NODES + 1);

    // Field widths of the input word.
    localparam int OP_W  = 2;
    localparam int IDX_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_REQUEST = 2'd0,
        OP_GRANT   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_CHECK   = 2'd3
    } t_op;

    // Broadcast command from the controller to every cell.
    typedef struct packed {
        logic              edge_en;
        t_op               op;
        logic [NODE_W-1:0] pnode;
        logic [NODE_W-1:0] rnode;
        logic              chk_clear;
        logic              chk_step;
    } t_cell_cmd;

endpackage

`default_nettype wire

// ===== rtl/core/ddg_cell.sv =====
`default_nettype none

module ddg_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [ddg_pkg::NODE_W-1:0]    i_node_id,
    input  wire ddg_pkg::t_cell_cmd            i_cmd,
    input  wire logic [ddg_pkg::NODES-1:0]     i_retired,
    input  wire logic                          i_chain_done,
    output logic                               o_retired,
    output logic                               o_chain_done
);
    import ddg_pkg::*;

    logic [NODES-1:0] r_row;
    logic [NODES-1:0] n_row;
    logic             r_retired;
    logic             n_retired;
    logic             w_is_p;
    logic             w_is_r;

    assign w_is_p = (i_node_id == i_cmd.pnode);
    assign w_is_r = (i_node_id == i_cmd.rnode);

    // Edge events touch only the row of the node that owns the edge.
    always_comb begin
        n_row = r_row;
        if (i_cmd.edge_en) begin
            case (i_cmd.op)
                OP_REQUEST: begin
                    if (w_is_p) n_row[i_cmd.rnode] = 1'b1;
                end
                OP_GRANT: begin
                    if (w_is_p) n_row[i_cmd.rnode] = 1'b0;
                    if (w_is_r) n_row[i_cmd.pnode] = 1'b1;
                end
                OP_RELEASE: begin
                    if (w_is_r) n_row[i_cmd.pnode] = 1'b0;
                end
                default: begin
                    n_row = r_row;
                end
            endcase
        end
    end

    // A live node retires once all of its edges lead to retired nodes.
    always_comb begin
        n_retired = r_retired;
        if (i_cmd.chk_clear) begin
            n_retired = 1'b0;
        end else if (i_cmd.chk_step && !r_retired && ((r_row & ~i_retired) == '0)) begin
            n_retired = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_retired <= 1'b0;
        end else begin
            r_row     <= n_row;
            r_retired <= n_retired;
        end
    end

    // The all-retired flag is handed from cell to cell down the row.
    assign o_retired    = r_retired;
    assign o_chain_done = i_chain_done & r_retired;

endmodule

`default_nettype wire

// ===== rtl/core/deadlock_graph_detector.sv =====
`default_nettype none

// Channel | Direction | Handshake          | Word
// --------+-----------+--------------------+------------------------------------------
// input   | in        | i_valid / o_ready  | i_operation, i_process_index, i_resource_index
// result  | out       | o_valid / i_ready  | o_deadlock (one word per check)
//
// A request, grant or release word yields no result. A check word runs one
// clear, NODES retire steps across the row of cells, then a load of the result register.
// Synchronous active-low reset clears the edge matrix at once; no clearing pass.
// A result waiting in the output register does not block input words; a second
// check then holds in its last cycle, with the input stalled, until that result is taken.

module deadlock_graph_detector (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [ddg_pkg::OP_W-1:0]      i_operation,
    input  wire logic [ddg_pkg::IDX_W-1:0]     i_process_index,
    input  wire logic [ddg_pkg::IDX_W-1:0]     i_resource_index,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_deadlock
);
    import ddg_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DONE
    } t_state;

    t_state          r_state;
    logic [CNT_W-1:0] r_cnt;
    logic            r_valid;
    logic            r_deadlock;

    t_cell_cmd       w_cmd;
    logic            w_accept;
    logic            w_in_range;
    logic            w_out_free;
    logic [NODES-1:0] w_retired;
    logic [NODES:0]  w_chain;

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_valid || i_ready;
    assign w_in_range = (int'(i_process_index) < COUNT) && (int'(i_resource_index) < COUNT);

    // Decode the accepted word into the command broadcast to all cells.
    always_comb begin
        w_cmd           = '0;
        w_cmd.op        = t_op'(i_operation);
        w_cmd.pnode     = NODE_W'(COUNT) + NODE_W'(i_process_index);
        w_cmd.rnode     = NODE_W'(i_resource_index);
        w_cmd.edge_en   = w_accept && (t_op'(i_operation) != OP_CHECK) && w_in_range;
        w_cmd.chk_clear = w_accept && (t_op'(i_operation) == OP_CHECK);
        w_cmd.chk_step  = (r_state == S_CHECK);
    end

    // Row of cells, one per graph node.
    assign w_chain[0] = 1'b1;
    for (genvar g = 0; g < NODES; g++) begin : g_cell
        ddg_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_node_id    (NODE_W'(g)),
            .i_cmd        (w_cmd),
            .i_retired    (w_retired),
            .i_chain_done (w_chain[g]),
            .o_retired    (w_retired[g]),
            .o_chain_done (w_chain[g+1])
        );
    end

    // Controller and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && w_out_free) begin
                r_valid <= 1'b1;
            end else if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_cmd.chk_clear) begin
                        r_state <= S_CHECK;
                        r_cnt   <= '0;
                    end
                end
                S_CHECK: begin
                    if (r_cnt == CNT_W'(NODES - 1)) begin
                        r_state <= S_DONE;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_deadlock <= !w_chain[NODES];
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid    = r_valid;
    assign o_deadlock = r_deadlock;

    // The step counter never runs past the node count.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_cnt < CNT_W'(NODES)))
        else $error("check step counter out of range");

    // A new result appears only out of the done state.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside of check completion");

    // An accepted check starts the retire steps next cycle.
    a_check_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.chk_clear |=> (r_state == S_CHECK) && (r_cnt == '0))
        else $error("check did not start");

    // The graph never changes while a check is walking it.
    a_no_edit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !w_cmd.edge_en)
        else $error("edge update during check");

endmodule

`default_nettype wire
